// ----- rtl/core/pfc_pkg.sv -----
// ----------------------------------------------------------------------------
// pfc_pkg
// Shared constants and table port bundles for the Playfair cipher unit.
// ----------------------------------------------------------------------------
package pfc_pkg;

  localparam int SIDE   = 5;
  localparam int CELLS  = 25;
  localparam int ALPHA  = 26;
  localparam int LW     = 5;   // letter index width
  localparam int CW     = 5;   // cell index width

  localparam logic [LW-1:0] LET_I = 5'd8;
  localparam logic [LW-1:0] LET_J = 5'd9;
  localparam logic [LW-1:0] LET_X = 5'd23;

  localparam logic [6:0] ASCII_A = 7'd65;

  // input beat commands
  typedef enum logic [1:0] {
    CMD_KEY    = 2'd0,
    CMD_FINISH = 2'd1,
    CMD_TEXT   = 2'd2,
    CMD_END    = 2'd3
  } cmd_t;

  // one place operation writes both tables at once
  typedef struct packed {
    logic          we;
    logic [CW-1:0] slot;     // key_square address, letter_cell data
    logic [LW-1:0] letter;   // key_square data, letter_cell address
  } tbl_wr_t;

  typedef struct packed {
    logic          key_re;
    logic [CW-1:0] key_addr;
    logic          cell_re;
    logic [LW-1:0] cell_addr;
  } tbl_rd_t;

endpackage

// ----- rtl/core/pfc_tables.sv -----
// ----------------------------------------------------------------------------
// pfc_tables
// Key square (cell -> letter) and its inverse (letter -> cell), one write
// and one registered read port each.
// ----------------------------------------------------------------------------
module pfc_tables (
  input  logic                     clk,
  input  pfc_pkg::tbl_wr_t         wr,
  input  pfc_pkg::tbl_rd_t         rd,
  output logic [pfc_pkg::LW-1:0]   key_rdata,
  output logic [pfc_pkg::CW-1:0]   cell_rdata
);

  logic [pfc_pkg::LW-1:0] key_square  [pfc_pkg::CELLS];
  logic [pfc_pkg::CW-1:0] letter_cell [pfc_pkg::ALPHA];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      key_square[wr.slot]    <= wr.letter;
      letter_cell[wr.letter] <= wr.slot;
    end
    if (rd.key_re) begin
      key_rdata <= key_square[rd.key_addr];
    end
    if (rd.cell_re) begin
      cell_rdata <= letter_cell[rd.cell_addr];
    end
  end

endmodule

// ----- rtl/core/pfc_rule.sv -----
// ----------------------------------------------------------------------------
// pfc_rule
// Row, column and rectangle rules: two cells in, two square indices out.
// ----------------------------------------------------------------------------
module pfc_rule (
  input  logic [pfc_pkg::CW-1:0] cell_a,
  input  logic [pfc_pkg::CW-1:0] cell_b,
  input  logic                   decrypt,
  output logic [pfc_pkg::CW-1:0] idx_a,
  output logic [pfc_pkg::CW-1:0] idx_b
);

  function automatic logic [2:0] row_of(input logic [pfc_pkg::CW-1:0] c);
    logic [2:0] r;
    priority if (c >= 5'd20) r = 3'd4;
    else if (c >= 5'd15)     r = 3'd3;
    else if (c >= 5'd10)     r = 3'd2;
    else if (c >= 5'd5)      r = 3'd1;
    else                     r = 3'd0;
    return r;
  endfunction

  function automatic logic [2:0] col_of(input logic [pfc_pkg::CW-1:0] c,
                                        input logic [2:0] r);
    logic [pfc_pkg::CW-1:0] base;
    logic [pfc_pkg::CW-1:0] diff;
    base = {r, 2'b00} + {2'b00, r};
    diff = c - base;
    return diff[2:0];
  endfunction

  // (v + sh) mod 5, v below 5
  function automatic logic [2:0] wrap(input logic [2:0] v, input logic [2:0] sh);
    logic [3:0] s;
    s = {1'b0, v} + {1'b0, sh};
    if (s >= 4'(pfc_pkg::SIDE)) s = s - 4'(pfc_pkg::SIDE);
    return s[2:0];
  endfunction

  function automatic logic [pfc_pkg::CW-1:0] at(input logic [2:0] r, input logic [2:0] c);
    return {r, 2'b00} + {2'b00, r} + {2'b00, c};
  endfunction

  logic [2:0] r1, c1, r2, c2, sh;

  always_comb begin
    r1 = row_of(cell_a);
    c1 = col_of(cell_a, r1);
    r2 = row_of(cell_b);
    c2 = col_of(cell_b, r2);
    sh = decrypt ? 3'(pfc_pkg::SIDE - 1) : 3'd1;
    if (r1 == r2) begin
      idx_a = at(r1, wrap(c1, sh));
      idx_b = at(r2, wrap(c2, sh));
    end else if (c1 == c2) begin
      idx_a = at(wrap(r1, sh), c1);
      idx_b = at(wrap(r2, sh), c2);
    end else begin
      idx_a = at(r1, c2);
      idx_b = at(r2, c1);
    end
  end

endmodule

// ----- rtl/core/playfair_digraph_cipher_unit.sv -----
// ----------------------------------------------------------------------------
// playfair_digraph_cipher_unit
// Playfair engine: builds the 5x5 key square from streamed key letters and
// enciphers or deciphers text letters pair by pair.
// ----------------------------------------------------------------------------
//
//  channel | signals                          | dir | beat
//  --------+----------------------------------+-----+---------------------------
//  in      | in_valid in_ready cmd char_in    | in  | one command + character
//  out     | out_valid out_ready letter_out   | out | one cipher letter,
//          | pair_last                        |     | pair_last on the second
//  cfg     | cfg_valid cfg_ready cfg_data     | in  | decrypt_mode, always ready
//
//  Input beats (the sequencer steps one table access at a time): a key
//  character is placed in S_KEY, finish walks one letter of the alphabet per
//  cycle in S_FILL, and a completed pair makes two letter_cell reads, then two
//  key_square reads, through single read ports (S_RA, S_RB, S_RC, S_K1, S_K2).
//  in_ready is high only while the sequencer is idle. A finished pair sits in
//  the output register; the next beat is taken meanwhile, and only its own
//  pair load waits for the output register to drain.
//  rst (synchronous) clears the control state, fill count and used mask; the
//  tables themselves are not cleared.
// ----------------------------------------------------------------------------
module playfair_digraph_cipher_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] cmd,
  input  logic [7:0] char_in,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [6:0] letter_out,
  output logic       pair_last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data
);

  localparam int LW = pfc_pkg::LW;
  localparam int CW = pfc_pkg::CW;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_KEY  = 4'd1;
  localparam logic [3:0] S_FILL = 4'd2;
  localparam logic [3:0] S_TEXT = 4'd3;
  localparam logic [3:0] S_EOM  = 4'd4;
  localparam logic [3:0] S_RA   = 4'd5;   // read cell of first letter
  localparam logic [3:0] S_RB   = 4'd6;   // read cell of second letter
  localparam logic [3:0] S_RC   = 4'd7;   // apply rule, read first letter
  localparam logic [3:0] S_K1   = 4'd8;   // read second letter
  localparam logic [3:0] S_K2   = 4'd9;   // load output register

  function automatic logic [LW-1:0] fold(input logic [LW-1:0] l);
    return (l == pfc_pkg::LET_J) ? pfc_pkg::LET_I : l;
  endfunction

  // ---- registers ----
  logic [3:0]      state;
  logic            decrypt_mode;
  logic [LW-1:0]   let_q;
  logic            islet_q;
  logic [CW-1:0]   fill_count;
  logic [pfc_pkg::ALPHA-1:0] letters_used;
  logic [LW-1:0]   walk;                 // alphabet walk for finish
  logic [LW-1:0]   pending_letter;
  logic            pending_valid;
  logic [LW-1:0]   previous_letter;
  logic            previous_valid;
  logic [LW-1:0]   pair_a, pair_b;
  logic [CW-1:0]   cell_a_q;
  logic [CW-1:0]   idx_b_q;
  logic [6:0]      stage0;
  logic [6:0]      out_l0, out_l1;
  logic [1:0]      out_cnt;

  // ---- input decode ----
  logic          in_fire;
  logic          ch_letter;
  logic [LW-1:0] ch_index;

  assign in_ready  = (state == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  always_comb begin
    ch_letter = 1'b0;
    ch_index  = '0;
    if (char_in >= 8'd65 && char_in <= 8'd90) begin
      ch_letter = 1'b1;
      ch_index  = LW'(char_in - 8'd65);
    end else if (char_in >= 8'd97 && char_in <= 8'd122) begin
      ch_letter = 1'b1;
      ch_index  = LW'(char_in - 8'd97);
    end
  end

  // ---- place logic shared by key and finish ----
  logic                      key_full;
  logic [CW-1:0]             base_fill;
  logic [pfc_pkg::ALPHA-1:0] base_used;
  logic [LW-1:0]             place_l;
  logic                      place_ok;

  always_comb begin
    key_full  = (fill_count >= CW'(pfc_pkg::CELLS));
    base_fill = fill_count;
    base_used = letters_used;
    place_l   = walk;
    if (state == S_KEY) begin
      place_l = fold(let_q);
      if (key_full) begin     // new key on a complete square restarts it
        base_fill = '0;
        base_used = '0;
      end
    end
    place_ok = !base_used[place_l] && (base_fill < CW'(pfc_pkg::CELLS));
    if (state == S_KEY)       place_ok = place_ok && islet_q;
    else if (state == S_FILL) place_ok = place_ok && (walk != pfc_pkg::LET_J);
    else                      place_ok = 1'b0;
  end

  // ---- text pairing ----
  logic          ins_x;
  logic          text_pair;
  logic [LW-1:0] text_a, text_b;

  always_comb begin
    ins_x     = !decrypt_mode && previous_valid && (previous_letter == let_q);
    text_pair = ins_x || pending_valid;
    text_a    = pending_valid ? pending_letter : pfc_pkg::LET_X;
    text_b    = (ins_x && pending_valid) ? pfc_pkg::LET_X : let_q;
  end

  // ---- tables and rule ----
  pfc_pkg::tbl_wr_t tbl_wr;
  pfc_pkg::tbl_rd_t tbl_rd;
  logic [LW-1:0]    key_rdata;
  logic [CW-1:0]    cell_rdata;
  logic [CW-1:0]    idx_a, idx_b;

  always_comb begin
    tbl_wr.we     = place_ok;
    tbl_wr.slot   = base_fill;
    tbl_wr.letter = place_l;
    tbl_rd.cell_re   = (state == S_RA) || (state == S_RB);
    tbl_rd.cell_addr = (state == S_RA) ? fold(pair_a) : fold(pair_b);
    tbl_rd.key_re    = (state == S_RC) || (state == S_K1);
    tbl_rd.key_addr  = (state == S_RC) ? idx_a : idx_b_q;
  end

  pfc_tables u_tables (
    .clk        (clk),
    .wr         (tbl_wr),
    .rd         (tbl_rd),
    .key_rdata  (key_rdata),
    .cell_rdata (cell_rdata)
  );

  pfc_rule u_rule (
    .cell_a  (cell_a_q),
    .cell_b  (cell_rdata),
    .decrypt (decrypt_mode),
    .idx_a   (idx_a),
    .idx_b   (idx_b)
  );

  // ---- output register ----
  assign out_valid  = (out_cnt != 2'd0);
  assign letter_out = (out_cnt == 2'd2) ? out_l0 : out_l1;
  assign pair_last  = (out_cnt == 2'd1);

  // ---- sequencer ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      decrypt_mode    <= 1'b0;
      fill_count      <= '0;
      letters_used    <= '0;
      pending_valid   <= 1'b0;
      pending_letter  <= '0;
      previous_valid  <= 1'b0;
      previous_letter <= '0;
      out_cnt         <= 2'd0;
      walk            <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        decrypt_mode <= cfg_data;
      end
      if (out_valid && out_ready) begin
        out_cnt <= out_cnt - 2'd1;
      end
      if (place_ok) begin
        fill_count   <= base_fill + CW'(1);
        letters_used <= base_used | (pfc_pkg::ALPHA'(1) << place_l);
      end else if (state == S_KEY && islet_q) begin
        fill_count   <= base_fill;
        letters_used <= base_used;
      end

      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            let_q   <= ch_index;
            islet_q <= ch_letter;
            walk    <= '0;
            unique case (cmd)
              pfc_pkg::CMD_KEY:    state <= S_KEY;
              pfc_pkg::CMD_FINISH: state <= S_FILL;
              pfc_pkg::CMD_TEXT:   state <= S_TEXT;
              pfc_pkg::CMD_END:    state <= S_EOM;
              default:             state <= S_IDLE;
            endcase
          end
        end
        S_KEY: state <= S_IDLE;
        S_FILL: begin
          walk <= walk + LW'(1);
          if (walk == LW'(pfc_pkg::ALPHA - 1)) state <= S_IDLE;
        end
        S_TEXT: begin
          if (!islet_q) begin
            state <= S_IDLE;
          end else begin
            previous_letter <= let_q;
            previous_valid  <= 1'b1;
            pair_a          <= text_a;
            pair_b          <= text_b;
            if (!text_pair) begin
              pending_letter <= let_q;
              pending_valid  <= 1'b1;
              state          <= S_IDLE;
            end else begin
              // X inserted after a pending letter leaves the new one open
              pending_letter <= let_q;
              pending_valid  <= ins_x && pending_valid;
              state          <= S_RA;
            end
          end
        end
        S_EOM: begin
          pair_a          <= pending_letter;
          pair_b          <= pfc_pkg::LET_X;
          pending_valid   <= 1'b0;
          pending_letter  <= '0;
          previous_valid  <= 1'b0;
          previous_letter <= '0;
          state           <= pending_valid ? S_RA : S_IDLE;
        end
        S_RA: state <= S_RB;
        S_RB: begin
          cell_a_q <= cell_rdata;
          state    <= S_RC;
        end
        S_RC: begin
          idx_b_q <= idx_b;
          state   <= S_K1;
        end
        S_K1: begin
          stage0 <= pfc_pkg::ASCII_A + {2'b00, key_rdata};
          state  <= S_K2;
        end
        S_K2: begin
          if (out_cnt == 2'd0) begin
            out_l0  <= stage0;
            out_l1  <= pfc_pkg::ASCII_A + {2'b00, key_rdata};
            out_cnt <= 2'd2;
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- tb/playfair_digraph_cipher_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// playfair_digraph_cipher_unit_test
// Self-checking bench for the Playfair cipher unit. Builds key squares,
// streams text in both modes and checks every cipher letter against an
// in-bench model of the square, the pairing and the X insertion.
// ----------------------------------------------------------------------------
module playfair_digraph_cipher_unit_test;

  localparam int SIDE  = pfc_pkg::SIDE;
  localparam int CELLS = pfc_pkg::CELLS;
  localparam int ALPHA = pfc_pkg::ALPHA;
  localparam int LW    = pfc_pkg::LW;
  localparam int CW    = pfc_pkg::CW;

  localparam int IDLE_LIMIT   = 3000;  // cycles with no beat on any channel
  localparam int DRAIN_CYCLES = 40;    // finish walks 26 letters, plus margin
  localparam int HOLD_CYCLES  = 400;   // long receiver hold-off
  localparam int ITEM_TARGET  = 1450;

  typedef struct packed {
    logic [6:0] letter;
    logic       last;
  } cipher_beat_t;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [1:0] cmd;
  logic [7:0] char_in;
  logic       out_valid;
  logic       out_ready;
  logic [6:0] letter_out;
  logic       pair_last;
  logic       cfg_valid;
  logic       cfg_ready;
  logic       cfg_data;

  playfair_digraph_cipher_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .char_in   (char_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .letter_out(letter_out),
    .pair_last (pair_last),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Cipher model state: the square in both directions, fill progress, the open
  // pair and the last text letter (unfolded) for X insertion.
  // --------------------------------------------------------------------------
  logic [LW-1:0]    sq_letter  [CELLS];
  logic [CW-1:0]    letter_pos [ALPHA];
  logic [ALPHA-1:0] used_mask;
  int               placed;
  int               open_letter;
  bit               open_valid;
  int               last_text;
  bit               last_text_valid;
  bit               decrypt;

  cipher_beat_t cipher_q[$];   // cipher letters still owed by the block

  int fail_count;
  int items_sent;
  int stall_cycles;
  bit no_idle;        // burst stretch: no gaps on either side
  bit hold_request;   // asks the receiver for one long hold-off

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Model
  // --------------------------------------------------------------------------
  function automatic int letter_index(logic [7:0] ch);
    if (ch >= "A" && ch <= "Z") return int'(ch) - int'("A");
    if (ch >= "a" && ch <= "z") return int'(ch) - int'("a");
    return -1;
  endfunction

  function automatic void place_in_square(int l);
    if (!used_mask[l] && placed < CELLS) begin
      sq_letter[placed] = LW'(l);
      letter_pos[l]     = CW'(placed);
      placed++;
      used_mask[l] = 1'b1;
    end
  endfunction

  function automatic logic [6:0] glyph_at(int r, int c);
    return pfc_pkg::ASCII_A + 7'(sq_letter[(r % SIDE) * SIDE + (c % SIDE)]);
  endfunction

  // row rule, column rule or rectangle rule; J shares the cell of I
  function automatic void encode_pair(int a, int b);
    int ca, cb, r1, c1, r2, c2, sh;
    cipher_beat_t first, second;
    if (a == pfc_pkg::LET_J) a = pfc_pkg::LET_I;
    if (b == pfc_pkg::LET_J) b = pfc_pkg::LET_I;
    ca = letter_pos[a] % CELLS;
    cb = letter_pos[b] % CELLS;
    r1 = ca / SIDE;
    c1 = ca % SIDE;
    r2 = cb / SIDE;
    c2 = cb % SIDE;
    sh = decrypt ? SIDE - 1 : 1;
    if (r1 == r2) begin
      first.letter  = glyph_at(r1, c1 + sh);
      second.letter = glyph_at(r2, c2 + sh);
    end else if (c1 == c2) begin
      first.letter  = glyph_at(r1 + sh, c1);
      second.letter = glyph_at(r2 + sh, c2);
    end else begin
      first.letter  = glyph_at(r1, c2);
      second.letter = glyph_at(r2, c1);
    end
    first.last  = 1'b0;
    second.last = 1'b1;
    cipher_q.push_back(first);
    cipher_q.push_back(second);
  endfunction

  function automatic void take_text_letter(int l);
    if (!open_valid) begin
      open_letter = l;
      open_valid  = 1'b1;
    end else begin
      open_valid = 1'b0;
      encode_pair(open_letter, l);
    end
  endfunction

  function automatic void predict_beat(pfc_pkg::cmd_t c, logic [7:0] ch);
    int l, k;
    l = letter_index(ch);
    case (c)
      pfc_pkg::CMD_KEY: begin
        if (l >= 0) begin
          if (l == pfc_pkg::LET_J) l = pfc_pkg::LET_I;
          // a key letter on a full square starts a fresh one
          if (placed >= CELLS) begin
            used_mask = '0;
            placed    = 0;
          end
          place_in_square(l);
        end
      end
      pfc_pkg::CMD_FINISH: begin
        for (k = 0; k < ALPHA; k++)
          if (k != pfc_pkg::LET_J) place_in_square(k);
      end
      pfc_pkg::CMD_TEXT: begin
        if (l >= 0) begin
          // stream-wide rule, compared before folding J
          if (!decrypt && last_text_valid && last_text == l)
            take_text_letter(pfc_pkg::LET_X);
          take_text_letter(l);
          last_text       = l;
          last_text_valid = 1'b1;
        end
      end
      default: begin
        if (open_valid) take_text_letter(pfc_pkg::LET_X);
        open_valid      = 1'b0;
        open_letter     = 0;
        last_text_valid = 1'b0;
        last_text       = 0;
      end
    endcase
  endfunction

  function automatic void clear_model();
    int k;
    for (k = 0; k < CELLS; k++) sq_letter[k] = '0;
    for (k = 0; k < ALPHA; k++) letter_pos[k] = '0;
    used_mask       = '0;
    placed          = 0;
    open_letter     = 0;
    open_valid      = 1'b0;
    last_text       = 0;
    last_text_valid = 1'b0;
    decrypt         = 1'b0;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // mostly zero, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] letter_char(int l);
    if ($urandom_range(0, 1)) return 8'("a") + 8'(l);
    return 8'("A") + 8'(l);
  endfunction

  // One input beat; called at a falling edge, returns at a falling edge.
  task automatic send_item(pfc_pkg::cmd_t c, logic [7:0] ch);
    int g;
    cmd      = c;
    char_in  = ch;
    in_valid = 1'b1;
    forever begin
      @(posedge clk);
      if (in_ready) break;
    end
    predict_beat(c, ch);
    items_sent++;
    @(negedge clk);
    in_valid = 1'b0;
    g = no_idle ? 0 : pick_gap();
    repeat (g) @(negedge clk);
  endtask

  // All owed letters in, then room for a finish walk still under way.
  task automatic wait_idle();
    while (cipher_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_mode(bit mode);
    cfg_data  = mode;
    cfg_valid = 1'b1;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    decrypt = mode;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random hold-offs, burst stretches, and one long hold on request
  // --------------------------------------------------------------------------
  initial begin : result_receiver
    int g;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
      end else begin
        g = no_idle ? 0 : pick_gap();
        if (g > 0) begin
          out_ready = 1'b0;
          repeat (g) @(negedge clk);
        end
      end
      out_ready = 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Result check: each output beat against the oldest owed letter
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    cipher_beat_t want;
    if (!rst && out_valid && out_ready) begin
      if (cipher_q.size() == 0) begin
        $error("unexpected beat: letter_out=%0d pair_last=%0b", letter_out, pair_last);
        fail_count++;
      end else begin
        want = cipher_q.pop_front();
        if (letter_out !== want.letter) begin
          $error("letter_out: expected %0d, got %0d", want.letter, letter_out);
          fail_count++;
        end
        if (pair_last !== want.last) begin
          $error("pair_last: expected %0b, got %0b", want.last, pair_last);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: too long with no beat on any channel ends the run.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= IDLE_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_mode_after_reset();
    write_mode(1'b0);
  endtask

  // lowercase j, J fold, repeats, non-letters, double finish, new key
  task automatic test_key_square();
    send_item(pfc_pkg::CMD_KEY, "j");
    send_item(pfc_pkg::CMD_KEY, "P");
    send_item(pfc_pkg::CMD_KEY, "p");
    send_item(pfc_pkg::CMD_KEY, "#");
    send_item(pfc_pkg::CMD_KEY, 8'h00);
    send_item(pfc_pkg::CMD_KEY, 8'hFF);
    send_item(pfc_pkg::CMD_KEY, "a");
    send_item(pfc_pkg::CMD_KEY, "Y");
    send_item(pfc_pkg::CMD_FINISH, 8'h00);
    send_item(pfc_pkg::CMD_FINISH, 8'hFF);
    // a key letter on a full square starts over
    send_item(pfc_pkg::CMD_KEY, "Z");
    send_item(pfc_pkg::CMD_FINISH, 8'h5A);
  endtask

  task automatic test_encrypt_text();
    send_item(pfc_pkg::CMD_TEXT, "h");
    send_item(pfc_pkg::CMD_TEXT, "H");    // equal letters: X goes between
    send_item(pfc_pkg::CMD_TEXT, "J");
    send_item(pfc_pkg::CMD_TEXT, "i");    // J then I: no X
    send_item(pfc_pkg::CMD_TEXT, "z");
    send_item(pfc_pkg::CMD_TEXT, 8'h80);  // dropped
    send_item(pfc_pkg::CMD_TEXT, "A");
    send_item(pfc_pkg::CMD_END, 8'h00);   // lone letter padded
    send_item(pfc_pkg::CMD_END, 8'hFF);   // nothing pending
  endtask

  // mode flips with a letter pending: no X on the repeat, pair deciphered
  task automatic test_decrypt_text();
    send_item(pfc_pkg::CMD_TEXT, "K");
    wait_idle();
    write_mode(1'b1);
    send_item(pfc_pkg::CMD_TEXT, "k");
    send_item(pfc_pkg::CMD_TEXT, "M");
    send_item(pfc_pkg::CMD_END, 8'h00);
  endtask

  // receiver holds off while letters keep coming, so the block backs up
  task automatic test_output_backpressure();
    int n;
    wait_idle();
    write_mode(1'b0);
    hold_request = 1'b1;
    no_idle      = 1'b1;
    for (n = 0; n < 40; n++)
      send_item(pfc_pkg::CMD_TEXT, letter_char($urandom_range(0, 25)));
    send_item(pfc_pkg::CMD_END, 8'h00);
    no_idle = 1'b0;
    while (hold_request) @(negedge clk);
    wait_idle();
  endtask

  task automatic build_random_key();
    int n, k;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 32) : $urandom_range(1, 12);
    for (k = 0; k < n; k++) begin
      if ($urandom_range(0, 6) == 0)
        send_item(pfc_pkg::CMD_KEY, 8'($urandom_range(0, 255)));
      else send_item(pfc_pkg::CMD_KEY, letter_char($urandom_range(0, 25)));
    end
    if ($urandom_range(0, 6) != 0)
      send_item(pfc_pkg::CMD_FINISH, 8'($urandom_range(0, 255)));
  endtask

  task automatic run_text_phase();
    int len, r, l;
    logic [7:0] ch;
    logic [7:0] prev_ch;
    prev_ch = "A";
    no_idle = ($urandom_range(0, 4) == 0);
    len = $urandom_range(20, 120);
    repeat (len) begin
      r = $urandom_range(0, 99);
      if (r < 6) begin
        send_item(pfc_pkg::CMD_END, 8'($urandom_range(0, 255)));
      end else if (r < 7) begin
        send_item(pfc_pkg::CMD_KEY, 8'($urandom_range(0, 255)));
      end else if (r < 8) begin
        send_item(pfc_pkg::CMD_FINISH, 8'($urandom_range(0, 255)));
      end else if (r < 16) begin
        send_item(pfc_pkg::CMD_TEXT, 8'($urandom_range(0, 255)));
      end else if (r < 30) begin
        // same letter again, either case
        ch = $urandom_range(0, 1) ? (prev_ch ^ 8'h20) : prev_ch;
        send_item(pfc_pkg::CMD_TEXT, ch);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 20) l = sq_letter[$urandom_range(0, SIDE - 1)];            // one row
        else if (r < 40) l = sq_letter[SIDE * $urandom_range(0, SIDE - 1)]; // one column
        else l = $urandom_range(0, 25);
        ch = letter_char(l);
        prev_ch = ch;
        send_item(pfc_pkg::CMD_TEXT, ch);
      end
    end
    no_idle = 1'b0;
  endtask

  task automatic test_random_traffic();
    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 2) == 0) begin
        wait_idle();
        write_mode(1'($urandom_range(0, 1)));
      end
      if ($urandom_range(0, 2) == 0) build_random_key();
      run_text_phase();
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst          = 1'b1;
    in_valid     = 1'b0;
    cmd          = pfc_pkg::CMD_KEY;
    char_in      = 8'h00;
    cfg_valid    = 1'b0;
    cfg_data     = 1'b0;
    no_idle      = 1'b0;
    hold_request = 1'b0;
    fail_count   = 0;
    items_sent   = 0;
    stall_cycles = 0;
    clear_model();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_mode_after_reset();
    test_key_square();       // square complete before any text
    test_encrypt_text();
    test_decrypt_text();
    test_output_backpressure();
    test_random_traffic();

    wait_idle();
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/pfc_pkg.sv
rtl/core/pfc_tables.sv
rtl/core/pfc_rule.sv
rtl/core/playfair_digraph_cipher_unit.sv
tb/playfair_digraph_cipher_unit_test.sv
